// ===== rtl/core/u8s_pkg.sv =====
package u8s_pkg;

    // queue between the scanner and the output sequencer
    localparam int unsigned C_QUEUE_DEPTH = 8;
    localparam int unsigned C_QUEUE_AW    = 3;

    // byte constants
    localparam logic [7:0] C_CHAR_QUESTION   = 8'h3F;
    localparam logic [7:0] C_CHAR_UNDERSCORE = 8'h5F;
    localparam logic [7:0] C_CTRL_LIMIT      = 8'h20;
    localparam logic [7:0] C_CHAR_DEL        = 8'h7F;
    localparam logic [7:0] C_ASCII_LIMIT     = 8'h80;
    localparam logic [7:0] C_LEAD2_MIN       = 8'hC2;
    localparam logic [7:0] C_LEAD3_E0        = 8'hE0;
    localparam logic [7:0] C_LEAD3_ED        = 8'hED;
    localparam logic [7:0] C_LEAD4_F0        = 8'hF0;
    localparam logic [7:0] C_LEAD4_F4        = 8'hF4;
    localparam logic [7:0] C_CONT_LO         = 8'h80;
    localparam logic [7:0] C_CONT_HI         = 8'hBF;
    localparam logic [7:0] C_E0_LO           = 8'hA0;
    localparam logic [7:0] C_ED_HI           = 8'h9F;
    localparam logic [7:0] C_F0_LO           = 8'h90;
    localparam logic [7:0] C_F4_HI           = 8'h8F;

    // results of one input byte, one to four output bytes
    typedef struct packed {
        logic [3:0][7:0] bytes;
        logic [3:0]      sub;
        logic [1:0]      last_idx;
        logic            str_last;
    } t_group;

endpackage

// ===== rtl/core/u8s_in_if.sv =====
interface u8s_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       in_last;

    modport source (output valid, output in_byte, output in_last, input ready);
    modport sink (input valid, input in_byte, input in_last, output ready);
endinterface

// ===== rtl/core/u8s_out_if.sv =====
interface u8s_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       substituted;
    logic       run_last;
    logic       string_last;

    modport source (output valid, output out_byte, output substituted,
                    output run_last, output string_last, input ready);
    modport sink (input valid, input out_byte, input substituted,
                  input run_last, input string_last, output ready);
endinterface

// ===== rtl/core/utf8_sanitizer_stream_unit.sv =====
// UTF-8 sanitizer, one byte in and zero to four bytes out per input byte.
// i_in carries the raw string bytes with in_last on the final byte.
// o_out carries sanitized bytes with substituted, run_last (last byte made
// from one input byte) and string_last (last byte of the string).
// Control bytes become '_', the lead of a bad or cut-short sequence becomes
// '?', well-formed sequences pass unchanged.
// The group made from an input transfer is written to the queue, and its
// first byte reaches o_out once the groups ahead of it have been sent.
// Throughput: one input byte per cycle while the queue has room; the output
// side moves one byte per cycle while o_out.ready is high.
// Input and output are parted by an eight-group queue; i_in.ready drops only
// when that queue is full, set by the output sequencer draining it.
// Bytes of an incomplete sequence are held until it completes or fails.
// Reset clears the held count and the queue; no item is lost on an output
// stall, the output holds its byte until the transfer.
module utf8_sanitizer_stream_unit
    import u8s_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    u8s_in_if.sink    i_in,
    u8s_out_if.source o_out
);

    logic   push;
    logic   pop;
    logic   q_ready;
    logic   q_valid;
    t_group grp_in;
    t_group grp_head;

    // scanner
    u8s_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in      (i_in),
        .i_q_ready (q_ready),
        .o_push    (push),
        .o_group   (grp_in)
    );

    // group queue
    u8s_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_group (grp_in),
        .o_ready (q_ready),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_head  (grp_head)
    );

    // output sequencer
    u8s_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (q_valid),
        .i_head  (grp_head),
        .o_pop   (pop),
        .o_out   (o_out)
    );

endmodule

// ===== rtl/core/u8s_front.sv =====
module u8s_front
    import u8s_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    u8s_in_if.sink       i_in,
    input  logic         i_q_ready,
    output logic         o_push,
    output t_group       o_group
);

    typedef struct packed {
        logic       ascii;
        logic       bad;
        logic [1:0] ext;
        logic [7:0] lo;
        logic [7:0] hi;
    } t_lead;

    // lead byte class and allowed range of the first continuation
    function automatic t_lead f_lead(input logic [7:0] b);
        t_lead l;
        l.ascii = 1'b0;
        l.bad   = 1'b0;
        l.ext   = 2'd0;
        l.lo    = C_CONT_LO;
        l.hi    = C_CONT_HI;
        if (b < C_ASCII_LIMIT) begin
            l.ascii = 1'b1;
        end else if (b[7:5] == 3'b110) begin
            l.bad = (b < C_LEAD2_MIN);
            l.ext = 2'd1;
        end else if (b[7:4] == 4'b1110) begin
            l.ext = 2'd2;
            if (b == C_LEAD3_E0) begin
                l.lo = C_E0_LO;
            end else if (b == C_LEAD3_ED) begin
                l.hi = C_ED_HI;
            end
        end else if (b[7:3] == 5'b11110 && b <= C_LEAD4_F4) begin
            l.ext = 2'd3;
            if (b == C_LEAD4_F0) begin
                l.lo = C_F0_LO;
            end else if (b == C_LEAD4_F4) begin
                l.hi = C_F4_HI;
            end
        end else begin
            l.bad = 1'b1;
        end
        return l;
    endfunction

    logic [7:0] r_held [3];
    logic [1:0] r_held_count, n_held_count;
    logic [1:0] r_needed, n_needed;

    logic       accept;
    logic       ctl;
    logic [7:0] cur;
    logic [7:0] sbuf [4];
    logic [2:0] num;
    logic [2:0] pos;
    logic [2:0] cnt;
    logic       stop;
    logic [1:0] pend_ext;
    logic [7:0] b;
    logic [7:0] c;
    t_lead      lead;
    logic [2:0] avail;
    logic       bad;
    logic [2:0] hold_n;
    t_group     grp;

    assign i_in.ready = i_q_ready;
    assign accept     = i_in.valid && i_in.ready;

    // scan held bytes plus the new byte, at most four lead positions
    always_comb begin
        cur = i_in.in_byte;
        ctl = (cur < C_CTRL_LIMIT) || (cur == C_CHAR_DEL);
        if (ctl) begin
            cur = C_CHAR_UNDERSCORE;
        end
        sbuf[0] = r_held[0];
        sbuf[1] = r_held[1];
        sbuf[2] = r_held[2];
        sbuf[3] = cur;
        sbuf[r_held_count] = cur;
        num = {1'b0, r_held_count} + 3'd1;

        pos      = 3'd0;
        cnt      = 3'd0;
        stop     = 1'b0;
        pend_ext = 2'd0;
        b        = 8'd0;
        c        = 8'd0;
        lead     = '0;
        avail    = 3'd0;
        bad      = 1'b0;
        grp      = '0;

        for (int it = 0; it < 4; it++) begin
            if (!stop && pos < num) begin
                b    = sbuf[pos[1:0]];
                lead = f_lead(b);
                if (lead.ascii) begin
                    grp.bytes[cnt[1:0]] = b;
                    grp.sub[cnt[1:0]]   = ctl && (pos == {1'b0, r_held_count});
                    cnt = cnt + 3'd1;
                    pos = pos + 3'd1;
                end else if (lead.bad) begin
                    grp.bytes[cnt[1:0]] = C_CHAR_QUESTION;
                    grp.sub[cnt[1:0]]   = 1'b1;
                    cnt = cnt + 3'd1;
                    pos = pos + 3'd1;
                end else begin
                    avail = num - pos - 3'd1;
                    bad   = 1'b0;
                    for (int k = 1; k < 4; k++) begin
                        if (3'(k) <= {1'b0, lead.ext} && 3'(k) <= avail) begin
                            c = sbuf[2'(pos + 3'(k))];
                            if (k == 1) begin
                                bad = bad || (c < lead.lo) || (c > lead.hi);
                            end else begin
                                bad = bad || (c < C_CONT_LO) || (c > C_CONT_HI);
                            end
                        end
                    end
                    if (bad) begin
                        grp.bytes[cnt[1:0]] = C_CHAR_QUESTION;
                        grp.sub[cnt[1:0]]   = 1'b1;
                        cnt = cnt + 3'd1;
                        pos = pos + 3'd1;
                    end else if (avail >= {1'b0, lead.ext}) begin
                        // complete sequence passes through unchanged
                        for (int k = 0; k < 4; k++) begin
                            if (3'(k) <= {1'b0, lead.ext}) begin
                                grp.bytes[2'(cnt + 3'(k))] = sbuf[2'(pos + 3'(k))];
                                grp.sub[2'(cnt + 3'(k))]   = 1'b0;
                            end
                        end
                        cnt = cnt + {1'b0, lead.ext} + 3'd1;
                        pos = pos + {1'b0, lead.ext} + 3'd1;
                    end else if (i_in.in_last) begin
                        grp.bytes[cnt[1:0]] = C_CHAR_QUESTION;
                        grp.sub[cnt[1:0]]   = 1'b1;
                        cnt = cnt + 3'd1;
                        pos = pos + 3'd1;
                    end else begin
                        pend_ext = lead.ext;
                        stop     = 1'b1;
                    end
                end
            end
        end

        grp.last_idx = 2'(cnt - 3'd1);
        grp.str_last = i_in.in_last;

        hold_n = num - pos;
        if (stop) begin
            n_held_count = hold_n[1:0];
            n_needed     = pend_ext;
        end else begin
            n_held_count = 2'd0;
            n_needed     = 2'd0;
        end
    end

    assign o_push  = accept && (cnt != 3'd0);
    assign o_group = grp;

    // pending sequence state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held_count <= 2'd0;
            r_needed     <= 2'd0;
        end else if (accept) begin
            r_held_count <= n_held_count;
            r_needed     <= n_needed;
        end
    end

    // held bytes, only entries below the count are read
    always_ff @(posedge i_clk) begin
        if (accept) begin
            for (int i = 0; i < 3; i++) begin
                r_held[i] <= sbuf[2'(pos + 3'(i))];
            end
        end
    end

`ifndef SYNTHESIS
    a_held_below_need: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_held_count != 2'd0) |-> (r_held_count <= r_needed))
        else $error("held bytes exceed what the lead calls for");

    a_last_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_in.in_last) |=> (r_held_count == 2'd0))
        else $error("string end left bytes held");

    a_no_push_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push |-> i_q_ready)
        else $error("push into a full queue");

    a_empty_needs_none: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_held_count == 2'd0) |-> (r_needed == 2'd0))
        else $error("continuation count without held bytes");
`endif

endmodule

// ===== rtl/core/u8s_queue.sv =====
module u8s_queue
    import u8s_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_group i_group,
    output logic   o_ready,
    input  logic   i_pop,
    output logic   o_valid,
    output t_group o_head
);

    t_group                r_mem [C_QUEUE_DEPTH];
    logic [C_QUEUE_AW-1:0] r_wptr;
    logic [C_QUEUE_AW-1:0] r_rptr;
    logic [C_QUEUE_AW:0]   r_count;

    assign o_ready = (r_count != (C_QUEUE_AW+1)'(C_QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_head  = r_mem[r_rptr];

    // pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= r_wptr + C_QUEUE_AW'(1);
            end
            if (i_pop) begin
                r_rptr <= r_rptr + C_QUEUE_AW'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + (C_QUEUE_AW+1)'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - (C_QUEUE_AW+1)'(1);
            end
        end
    end

    // group storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_group;
        end
    end

endmodule

// ===== rtl/core/u8s_back.sv =====
module u8s_back
    import u8s_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    input  t_group    i_head,
    output logic      o_pop,
    u8s_out_if.source o_out
);

    logic [1:0] r_idx;
    logic       at_last;
    logic       xfer;

    assign at_last = (r_idx == i_head.last_idx);
    assign xfer    = o_out.valid && o_out.ready;
    assign o_pop   = xfer && at_last;

    // one byte of the head group per transfer
    assign o_out.valid       = i_valid;
    assign o_out.out_byte    = i_head.bytes[r_idx];
    assign o_out.substituted = i_head.sub[r_idx];
    assign o_out.run_last    = at_last;
    assign o_out.string_last = at_last && i_head.str_last;

    // byte index within the group
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= 2'd0;
        end else if (xfer) begin
            r_idx <= at_last ? 2'd0 : r_idx + 2'd1;
        end
    end

`ifndef SYNTHESIS
    a_idx_in_group: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid |-> (r_idx <= i_head.last_idx))
        else $error("byte index past end of group");
`endif

endmodule
